@@ rtl/rsi_pkg.sv @@
// Shared types and constants for the ray-sphere intersection unit.
`default_nettype none

package rsi_pkg;

   localparam int WORD_BITS = 32;
   localparam int A_BITS    = 2 * WORD_BITS;
   localparam int HB_BITS   = 2 * WORD_BITS + 2;
   localparam int C_BITS    = 2 * WORD_BITS + 3;
   localparam int DISC_BITS = 4 * WORD_BITS + 4;
   localparam int ROOT_BITS = DISC_BITS / 2;

   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [1:0] CSR_RADIUS   = 2'd3;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] origin_x;
      logic signed [WORD_BITS-1:0] origin_y;
      logic signed [WORD_BITS-1:0] origin_z;
      logic signed [WORD_BITS-1:0] dir_x;
      logic signed [WORD_BITS-1:0] dir_y;
      logic signed [WORD_BITS-1:0] dir_z;
   } ray_type;

   typedef struct packed {
      logic                        hit;
      logic signed [WORD_BITS-1:0] hit_distance;
   } hit_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] center_x;
      logic signed [WORD_BITS-1:0] center_y;
      logic signed [WORD_BITS-1:0] center_z;
      logic        [WORD_BITS-2:0] sphere_radius;
   } sphere_type;

endpackage

`default_nettype wire

@@ rtl/rsi_front.sv @@
// Front stages: oc, products and the sums a, half_b and c.
`default_nettype none

module rsi_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  rsi_pkg::ray_type                     in_ray,
   input  rsi_pkg::sphere_type                  sphere,
   output logic                                 out_valid,
   output logic        [rsi_pkg::A_BITS-1:0]    out_a,
   output logic signed [rsi_pkg::HB_BITS-1:0]   out_hb,
   output logic signed [rsi_pkg::C_BITS-1:0]    out_c
);
   import rsi_pkg::*;

   localparam int W = WORD_BITS;

   logic v1_ff, v2_ff, v3_ff;
   logic signed [W:0]   ocx_ff, ocy_ff, ocz_ff;
   logic signed [W-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [2*W-1:0] ddx_ff, ddy_ff, ddz_ff;
   logic signed [2*W:0]   odx_ff, ody_ff, odz_ff;
   logic signed [2*W+1:0] oox_ff, ooy_ff, ooz_ff;
   logic        [2*W-3:0] rr_ff;
   logic        [A_BITS-1:0]         a_in, a_ff;
   logic signed [HB_BITS-1:0]        hb_in, hb_ff;
   logic signed [C_BITS-1:0]         c_in, c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ocx_ff <= (W+1)'(in_ray.origin_x) - (W+1)'(sphere.center_x);
         ocy_ff <= (W+1)'(in_ray.origin_y) - (W+1)'(sphere.center_y);
         ocz_ff <= (W+1)'(in_ray.origin_z) - (W+1)'(sphere.center_z);
         dx_ff  <= in_ray.dir_x;
         dy_ff  <= in_ray.dir_y;
         dz_ff  <= in_ray.dir_z;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ddx_ff <= dx_ff * dx_ff;
         ddy_ff <= dy_ff * dy_ff;
         ddz_ff <= dz_ff * dz_ff;
         odx_ff <= ocx_ff * dx_ff;
         ody_ff <= ocy_ff * dy_ff;
         odz_ff <= ocz_ff * dz_ff;
         oox_ff <= ocx_ff * ocx_ff;
         ooy_ff <= ocy_ff * ocy_ff;
         ooz_ff <= ocz_ff * ocz_ff;
         rr_ff  <= sphere.sphere_radius * sphere.sphere_radius;
      end
   end

   assign a_in  = A_BITS'(ddx_ff) + A_BITS'(ddy_ff) + A_BITS'(ddz_ff);
   assign hb_in = HB_BITS'(odx_ff) + HB_BITS'(ody_ff) + HB_BITS'(odz_ff);
   assign c_in  = C_BITS'(oox_ff) + C_BITS'(ooy_ff) + C_BITS'(ooz_ff)
                - C_BITS'($signed({1'b0, rr_ff}));

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff  <= a_in;
         hb_ff <= hb_in;
         c_ff  <= c_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_a     = a_ff;
   assign out_hb    = hb_ff;
   assign out_c     = c_ff;

endmodule

`default_nettype wire

@@ rtl/rsi_mul.sv @@
// Two-stage signed multiplier built from four half-width partial products.
`default_nettype none

module rsi_mul #(
   parameter int X_BITS,
   parameter int Y_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [X_BITS-1:0]        x,
   input  logic signed [Y_BITS-1:0]        y,
   output logic                            out_valid,
   output logic signed [X_BITS+Y_BITS-1:0] p
);
   localparam int XL = X_BITS / 2;
   localparam int XH = X_BITS - XL;
   localparam int YL = Y_BITS / 2;
   localparam int YH = Y_BITS - YL;
   localparam int P_BITS = X_BITS + Y_BITS;

   logic v1_ff, v2_ff;
   logic        [XL+YL-1:0] ll_ff;
   logic signed [XL+YH:0]   lh_ff;
   logic signed [XH+YL:0]   hl_ff;
   logic signed [XH+YH-1:0] hh_ff;
   logic signed [P_BITS-1:0] p_in, p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= x[XL-1:0] * y[YL-1:0];
         lh_ff <= $signed({1'b0, x[XL-1:0]}) * $signed(y[Y_BITS-1:YL]);
         hl_ff <= $signed(x[X_BITS-1:XL]) * $signed({1'b0, y[YL-1:0]});
         hh_ff <= $signed(x[X_BITS-1:XL]) * $signed(y[Y_BITS-1:YL]);
      end
   end

   assign p_in = $signed(P_BITS'(ll_ff))
               + (P_BITS'(lh_ff) <<< YL)
               + (P_BITS'(hl_ff) <<< XL)
               + (P_BITS'(hh_ff) <<< (XL + YL));

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign out_valid = v2_ff;
   assign p         = p_ff;

endmodule

`default_nettype wire

@@ rtl/rsi_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with sideband data.
`default_nettype none

module rsi_sqrt #(
   parameter int IN_BITS,
   parameter int SB_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [IN_BITS-1:0]    radicand,
   input  logic [SB_BITS-1:0]    in_sb,
   output logic                  out_valid,
   output logic [IN_BITS/2-1:0]  root,
   output logic [SB_BITS-1:0]    out_sb
);
   localparam int N        = IN_BITS / 2;
   localparam int REM_BITS = N + 2;

   logic                v_ff    [N];
   logic [N-1:0]        root_ff [N];
   logic [SB_BITS-1:0]  sb_ff   [N];
   logic [REM_BITS-1:0] rem_ff  [N-1];
   logic [IN_BITS-1:0]  rad_ff  [N-1];

   for (genvar g = 0; g < N; g++) begin : g_stage
      logic [REM_BITS-1:0] rem_src, rem_t, trial;
      logic [N-1:0]        root_src;
      logic [IN_BITS-1:0]  rad_src;
      logic [SB_BITS-1:0]  sb_src;
      logic                v_src, ge;

      if (g == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
         assign sb_src   = in_sb;
         assign v_src    = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign rad_src  = rad_ff[g-1];
         assign sb_src   = sb_ff[g-1];
         assign v_src    = v_ff[g-1];
      end

      assign rem_t = {rem_src[REM_BITS-3:0], rad_src[IN_BITS-1 -: 2]};
      assign trial = {root_src, 2'b01};
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[g] <= {root_src[N-2:0], ge};
            sb_ff[g]   <= sb_src;
         end
      end

      if (g < N - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g] <= ge ? rem_t - trial : rem_t;
               rad_ff[g] <= rad_src << 2;
            end
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign root      = root_ff[N-1];
   assign out_sb    = sb_ff[N-1];

endmodule

`default_nettype wire

@@ rtl/rsi_div.sv @@
// Numerator, pipelined restoring divide by a, saturation and result register.
`default_nettype none

module rsi_div #(
   parameter int FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic                                in_miss,
   input  logic signed [rsi_pkg::HB_BITS-1:0]  in_hb,
   input  logic        [rsi_pkg::ROOT_BITS-1:0] in_root,
   input  logic        [rsi_pkg::A_BITS-1:0]   in_a,
   output logic                                out_valid,
   output rsi_pkg::hit_type                    out_result
);
   import rsi_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int NW = HB_BITS + 2;
   localparam int MW = NW - 1;
   localparam int DW = MW + FRAC_BITS;
   localparam int HW = DW - W;
   localparam logic [W-1:0] NEG_ONE = {W{1'b1}} << FRAC_BITS;
   localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

   // numerator and magnitude
   logic signed [NW-1:0] n_in;
   logic        [MW-1:0] mag_in, mag_ff;
   logic                 v0_ff, miss0_ff, neg0_ff;
   logic   [A_BITS-1:0]  a0_ff;

   assign n_in   = -NW'(in_hb) - $signed(NW'(in_root));
   assign mag_in = n_in[NW-1] ? MW'(-n_in) : MW'(n_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         miss0_ff <= in_miss;
         neg0_ff  <= n_in[NW-1];
         mag_ff   <= mag_in;
         a0_ff    <= in_a;
      end
   end

   // overflow check and divider setup
   logic [DW-1:0]     dvd;
   logic [HW-1:0]     dvd_hi;
   logic              v1_ff, miss1_ff, neg1_ff, ovf1_ff;
   logic [A_BITS-1:0] a1_ff, rem1_ff;
   logic [W-1:0]      qs1_ff;

   assign dvd    = {mag_ff, FRAC_BITS'(0)};
   assign dvd_hi = dvd[DW-1:W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         miss1_ff <= miss0_ff;
         neg1_ff  <= neg0_ff;
         ovf1_ff  <= A_BITS'(dvd_hi) >= a0_ff;
         a1_ff    <= a0_ff;
         rem1_ff  <= A_BITS'(dvd_hi);
         qs1_ff   <= dvd[W-1:0];
      end
   end

   // one quotient bit per stage
   logic              v_ff    [W];
   logic              miss_ff [W];
   logic              neg_ff  [W];
   logic              ovf_ff  [W];
   logic [W-1:0]      qs_ff   [W];
   logic [A_BITS-1:0] a_ff    [W-1];
   logic [A_BITS-1:0] rem_ff  [W-1];

   for (genvar g = 0; g < W; g++) begin : g_stage
      logic              v_src, miss_src, neg_src, ovf_src, ge;
      logic [W-1:0]      qs_src;
      logic [A_BITS-1:0] a_src, rem_src;
      logic [A_BITS:0]   rem_t;

      if (g == 0) begin : g_first
         assign v_src    = v1_ff;
         assign miss_src = miss1_ff;
         assign neg_src  = neg1_ff;
         assign ovf_src  = ovf1_ff;
         assign qs_src   = qs1_ff;
         assign a_src    = a1_ff;
         assign rem_src  = rem1_ff;
      end else begin : g_next
         assign v_src    = v_ff[g-1];
         assign miss_src = miss_ff[g-1];
         assign neg_src  = neg_ff[g-1];
         assign ovf_src  = ovf_ff[g-1];
         assign qs_src   = qs_ff[g-1];
         assign a_src    = a_ff[g-1];
         assign rem_src  = rem_ff[g-1];
      end

      assign rem_t = {rem_src, qs_src[W-1]};
      assign ge    = rem_t >= {1'b0, a_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            miss_ff[g] <= miss_src;
            neg_ff[g]  <= neg_src;
            ovf_ff[g]  <= ovf_src;
            qs_ff[g]   <= {qs_src[W-2:0], ge};
         end
      end

      if (g < W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[g]   <= a_src;
               rem_ff[g] <= A_BITS'(ge ? rem_t - {1'b0, a_src} : rem_t);
            end
         end
      end
   end

   // saturation and result register
   logic [W-1:0] q;
   logic         out_v_ff;
   hit_type      result_in, result_ff;

   assign q = qs_ff[W-1];

   always_comb begin
      result_in.hit = 1'b1;
      if (miss_ff[W-1]) begin
         result_in.hit          = 1'b0;
         result_in.hit_distance = NEG_ONE;
      end else if (neg_ff[W-1]) begin
         if (ovf_ff[W-1] || (q[W-1] && |q[W-2:0])) begin
            result_in.hit_distance = MAX_NEG;
         end else begin
            result_in.hit_distance = -q;
         end
      end else begin
         if (ovf_ff[W-1] || q[W-1]) begin
            result_in.hit_distance = MAX_POS;
         end else begin
            result_in.hit_distance = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

@@ rtl/ray_sphere_intersect_unit.sv @@
// Ray-sphere intersection unit: sphere registers and the full intersection pipeline.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   ray_type (origin, direction)
//   rsp_      out         rsp_valid / rsp_stall   hit_type (hit, hit_distance)
//   csr_      in          csr_valid / csr_ready   csr_index, csr_data
//
// One ray per cycle while the result side is not stalled. Most of the pipeline depth comes from
// the one-bit-per-stage square root (2*WORD_BITS+2 stages) and divider (WORD_BITS).
// Synchronous reset clears all valid bits and loads the sphere registers.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module ray_sphere_intersect_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rsi_pkg::ray_type                req_ray,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rsi_pkg::hit_type                rsp_result,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [rsi_pkg::WORD_BITS-1:0]   csr_data
);
   import rsi_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic [W-1:0] NEG_ONE = {W{1'b1}} << FRAC_BITS;
   localparam int SB_BITS = 1 + A_BITS + HB_BITS;

   sphere_type sphere_ff;
   logic       en;

   assign csr_ready = 1'b1;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         sphere_ff.center_x      <= '0;
         sphere_ff.center_y      <= '0;
         sphere_ff.center_z      <= {W{1'b1}} << (FRAC_BITS + 1);
         sphere_ff.sphere_radius <= (W-1)'(1) << (FRAC_BITS - 1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_X: sphere_ff.center_x      <= csr_data;
            CSR_CENTER_Y: sphere_ff.center_y      <= csr_data;
            CSR_CENTER_Z: sphere_ff.center_z      <= csr_data;
            CSR_RADIUS:   sphere_ff.sphere_radius <= csr_data[W-2:0];
         endcase
      end
   end

   logic                      fr_valid;
   logic        [A_BITS-1:0]  fr_a;
   logic signed [HB_BITS-1:0] fr_hb;
   logic signed [C_BITS-1:0]  fr_c;

   rsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_ray    (req_ray),
      .sphere    (sphere_ff),
      .out_valid (fr_valid),
      .out_a     (fr_a),
      .out_hb    (fr_hb),
      .out_c     (fr_c)
   );

   logic                               sq_valid, ac_valid;
   logic signed [2*HB_BITS-1:0]        hbsq;
   logic signed [A_BITS+C_BITS:0]      ac;

   rsi_mul #(.X_BITS(HB_BITS), .Y_BITS(HB_BITS)) u_mul_hb (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .x         (fr_hb),
      .y         (fr_hb),
      .out_valid (sq_valid),
      .p         (hbsq)
   );

   rsi_mul #(.X_BITS(A_BITS + 1), .Y_BITS(C_BITS)) u_mul_ac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .x         ($signed({1'b0, fr_a})),
      .y         (fr_c),
      .out_valid (ac_valid),
      .p         (ac)
   );

   logic        [A_BITS-1:0]  a_d1_ff, a_d2_ff, a_d3_ff;
   logic signed [HB_BITS-1:0] hb_d1_ff, hb_d2_ff, hb_d3_ff;
   logic signed [DISC_BITS-1:0] disc_in;
   logic        [DISC_BITS-1:0] disc_ff;
   logic                        disc_v_ff, miss_ff;

   assign disc_in = DISC_BITS'(hbsq) - DISC_BITS'(ac);

   always_ff @(posedge clock) begin
      if (en) begin
         a_d1_ff  <= fr_a;
         a_d2_ff  <= a_d1_ff;
         a_d3_ff  <= a_d2_ff;
         hb_d1_ff <= fr_hb;
         hb_d2_ff <= hb_d1_ff;
         hb_d3_ff <= hb_d2_ff;
         disc_ff  <= disc_in;
         miss_ff  <= (a_d2_ff == '0) || disc_in[DISC_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disc_v_ff <= 1'b0;
      end else if (en) begin
         disc_v_ff <= sq_valid;
      end
   end

   logic                 rt_valid;
   logic [ROOT_BITS-1:0] rt_root;
   logic [SB_BITS-1:0]   rt_sb;

   rsi_sqrt #(.IN_BITS(DISC_BITS), .SB_BITS(SB_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (disc_v_ff),
      .radicand  (disc_ff),
      .in_sb     ({miss_ff, a_d3_ff, hb_d3_ff}),
      .out_valid (rt_valid),
      .root      (rt_root),
      .out_sb    (rt_sb)
   );

   rsi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (rt_valid),
      .in_miss    (rt_sb[SB_BITS-1]),
      .in_hb      ($signed(rt_sb[HB_BITS-1:0])),
      .in_root    (rt_root),
      .in_a       (rt_sb[HB_BITS +: A_BITS]),
      .out_valid  (rsp_valid),
      .out_result (rsp_result)
   );

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result.hit |-> rsp_result.hit_distance == NEG_ONE)
      else $error("miss without -1.0 distance");

   a_sphere_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && !csr_valid |=> $stable(sphere_ff))
      else $error("sphere registers changed without a write");

   a_frozen: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(disc_ff) && $stable(rt_root))
      else $error("pipeline moved while stalled");

   a_mul_align: assert property (@(posedge clock) disable iff (reset)
      ac_valid == sq_valid)
      else $error("multiplier valid bits out of step");
`endif

endmodule

`default_nettype wire

@@ tb/sv/ray_sphere_intersect_unit_tb.sv @@
// Self-checking testbench for the ray-sphere intersection unit.
module ray_sphere_intersect_unit_tb;
   import rsi_pkg::*;

   localparam int FRAC = 16;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int PIPE_DRAIN = 130;
   localparam logic signed [WORD_BITS-1:0] MINUS_ONE = -32'sd65536;

   typedef struct {
      ray_type ray;
      bit      pinned;
      hit_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   ray_type req_ray;
   logic rsp_valid;
   logic rsp_stall;
   hit_type rsp_result;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [WORD_BITS-1:0] csr_data;

   logic signed [WORD_BITS-1:0] sph_cx, sph_cy, sph_cz;
   logic [WORD_BITS-2:0] sph_rad;

   hit_type hit_q[$];
   stim_row_type dir_tbl[$];
   bit pin_en;
   hit_type pin_val;
   int idle_pct, stall_pct, hold_cnt;
   int errors, cycles;

   ray_sphere_intersect_unit #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_ray(req_ray),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result(rsp_result),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic hit_type trace_ray(ray_type r);
      logic signed [255:0] ox, oy, oz, dx, dy, dz, a, hb, c, disc;
      logic signed [255:0] rad, root, cand, n, mag, q, lim;
      bit neg;
      hit_type h;
      ox = $signed(r.origin_x) - $signed(sph_cx);
      oy = $signed(r.origin_y) - $signed(sph_cy);
      oz = $signed(r.origin_z) - $signed(sph_cz);
      dx = $signed(r.dir_x);
      dy = $signed(r.dir_y);
      dz = $signed(r.dir_z);
      rad = sph_rad;
      a = dx * dx + dy * dy + dz * dz;
      hb = ox * dx + oy * dy + oz * dz;
      c = ox * ox + oy * oy + oz * oz - rad * rad;
      disc = hb * hb - a * c;
      if (a == 0 || disc < 0) begin
         h.hit = 1'b0;
         h.hit_distance = MINUS_ONE;
         return h;
      end
      root = 0;
      for (int k = 127; k >= 0; k--) begin
         cand = root | (256'sd1 <<< k);
         if (cand * cand <= disc) root = cand;
      end
      n = -hb - root;
      neg = n < 0;
      mag = neg ? -n : n;
      q = (mag <<< FRAC) / a;
      lim = neg ? (256'sd1 <<< (WORD_BITS - 1)) : ((256'sd1 <<< (WORD_BITS - 1)) - 1);
      if (q > lim) q = lim;
      if (neg) q = -q;
      h.hit = 1'b1;
      h.hit_distance = q[WORD_BITS-1:0];
      return h;
   endfunction

   // input and csr acceptance, result checking
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            hit_q.push_back(pin_en ? pin_val : trace_ray(req_ray));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X: sph_cx <= csr_data;
               CSR_CENTER_Y: sph_cy <= csr_data;
               CSR_CENTER_Z: sph_cz <= csr_data;
               CSR_RADIUS:   sph_rad <= csr_data[WORD_BITS-2:0];
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (hit_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction hit=%0b dist=%h", $time,
                        rsp_result.hit, rsp_result.hit_distance);
            end else begin
               hit_type w;
               w = hit_q.pop_front();
               if (w.hit !== rsp_result.hit) begin
                  errors++;
                  $display("%0t: hit expected %0b actual %0b", $time, w.hit, rsp_result.hit);
               end
               if (w.hit_distance !== rsp_result.hit_distance) begin
                  errors++;
                  $display("%0t: hit_distance expected %h actual %h", $time,
                           w.hit_distance, rsp_result.hit_distance);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side backpressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cnt > 0) begin
            rsp_stall = 1'b1;
            hold_cnt--;
         end else begin
            rsp_stall = $urandom_range(99) < stall_pct;
         end
      end
   end

   task automatic send_ray(ray_type r, bit pinned, hit_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_ray = r;
      pin_en = pinned;
      pin_val = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [WORD_BITS-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (hit_q.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void add_row(logic [WORD_BITS-1:0] ox, oy, oz, dx, dy, dz,
                                   bit pinned, logic h, logic [WORD_BITS-1:0] want_dist);
      stim_row_type s;
      s.ray = '{ox, oy, oz, dx, dy, dz};
      s.pinned = pinned;
      s.want.hit = h;
      s.want.hit_distance = want_dist;
      dir_tbl.push_back(s);
   endfunction

   function automatic logic [WORD_BITS-1:0] rand_word();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return 0;
         default: return $signed($urandom_range(1 << 19)) - (1 << 18);
      endcase
   endfunction

   function automatic ray_type rand_ray();
      ray_type r;
      int unsigned sel;
      logic signed [WORD_BITS-1:0] off [3];
      sel = $urandom_range(99);
      if (sel < 70) begin
         for (int i = 0; i < 3; i++)
            off[i] = $signed($urandom_range(1 << 20)) - (1 << 19);
         r.origin_x = sph_cx + off[0];
         r.origin_y = sph_cy + off[1];
         r.origin_z = sph_cz + off[2];
         r.dir_x = -off[0] + ($signed($urandom_range(1 << 16)) - (1 << 15));
         r.dir_y = -off[1] + ($signed($urandom_range(1 << 16)) - (1 << 15));
         r.dir_z = -off[2] + ($signed($urandom_range(1 << 16)) - (1 << 15));
      end else if (sel < 90) begin
         r = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
      end else begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      return r;
   endfunction

   initial begin
      hit_type none;
      none = '0;
      errors = 0;
      cycles = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_cnt = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ray = '0;
      pin_en = 1'b0;
      pin_val = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CENTER_X;
      csr_data = '0;
      sph_cx = 0;
      sph_cy = 0;
      sph_cz = -32'sd131072;
      sph_rad = 31'd32768;

      // after reset: zero direction, straight hit at 1.5, clean miss, extreme origins
      add_row(0, 0, 0, 0, 0, 0, 1, 1'b0, MINUS_ONE);
      add_row(0, 0, 0, 0, 0, -32'sd65536, 1, 1'b1, 32'h00018000);
      add_row(0, 0, 0, 32'h10000, 0, 0, 1, 1'b0, MINUS_ONE);
      add_row(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 1, 1'b0, MINUS_ONE);
      add_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 1, 1'b0, MINUS_ONE);
      // sphere behind origin, saturating roots, extreme fields
      add_row(0, 0, 0, 0, 0, 32'h10000, 0, 0, 0);
      add_row(0, 0, 32'h7fff0000, 0, 0, -32'sd1, 0, 0, 0);
      add_row(0, 0, 32'h80000000, 0, 0, 32'sd1, 0, 0, 0);
      add_row(0, 0, 32'h80000000, 0, 0, -32'sd1, 0, 0, 0);
      add_row(0, 0, 32'hfffe8000, 0, 0, 32'sd1, 0, 0, 0);
      add_row(32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0);
      add_row(32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
      add_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
      add_row(32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
      add_row(0, 0, 0, 32'sd1, 0, 0, 0, 0, 0);
      add_row(0, 32'h8000, 0, 0, 0, -32'sd65536, 0, 0, 0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tbl[i]) send_ray(dir_tbl[i].ray, dir_tbl[i].pinned, dir_tbl[i].want);
      pin_en = 1'b0;

      for (int ph = 0; ph < 7; ph++) begin
         drain();
         case (ph)
            1: begin
               write_csr(CSR_CENTER_X, 32'h7fffffff);
               write_csr(CSR_CENTER_Y, 32'h80000000);
               write_csr(CSR_CENTER_Z, $urandom);
               write_csr(CSR_RADIUS, 32'hffffffff);
            end
            2: begin
               write_csr(CSR_CENTER_X, 0);
               write_csr(CSR_CENTER_Y, 0);
               write_csr(CSR_CENTER_Z, 0);
               write_csr(CSR_RADIUS, 0);
            end
            3, 6: begin
               write_csr(CSR_CENTER_X, $urandom);
               write_csr(CSR_CENTER_Y, $urandom);
               write_csr(CSR_CENTER_Z, $urandom);
               write_csr(CSR_RADIUS, $urandom);
            end
            4: begin
               write_csr(CSR_CENTER_X, 32'h10000);
               write_csr(CSR_CENTER_Y, -32'sd131072);
               write_csr(CSR_CENTER_Z, -32'sd327680);
               write_csr(CSR_RADIUS, 32'h18000);
            end
            5: begin
               write_csr(CSR_CENTER_X, $signed($urandom_range(1 << 20)) - (1 << 19));
               write_csr(CSR_CENTER_Y, $signed($urandom_range(1 << 20)) - (1 << 19));
               write_csr(CSR_CENTER_Z, $signed($urandom_range(1 << 20)) - (1 << 19));
               write_csr(CSR_RADIUS, $urandom_range(1 << 19));
            end
            default: ;
         endcase
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         if (ph == 4) hold_cnt = 400;
         for (int i = 0; i < 115; i++) send_ray(rand_ray(), 1'b0, none);
      end

      drain();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
